/* src/wbss_pkg.sv */
// shared constants, codes and types for the wildcard byte signature scanner
`timescale 1ns / 1ps
package wbss_pkg;

  localparam int MAX_PATTERN = 128;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int BYTE_W      = 8;
  localparam int ENTRY_W     = 7;
  localparam int CFG_W       = 8;
  localparam int OFS_W       = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SCAN = 1'b1;

  typedef struct packed {
    logic              any;
    logic [BYTE_W-1:0] value;
  } pat_entry_t;

  typedef struct packed {
    logic             scan_en;
    logic             rot_en;
    logic             load_en;
    logic [IDX_W-1:0] load_addr;
    logic [IDX_W-1:0] offset;
  } row_ctrl_t;

endpackage

/* src/wbss_in_if.sv */
// input channel: load and scan items
`timescale 1ns / 1ps
interface wbss_in_if;
  import wbss_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [ENTRY_W-1:0] entry_index;
  logic [BYTE_W-1:0]  item_byte;
  logic               wildcard_req;
  logic               last_byte;

  modport source (output valid, mode, entry_index, item_byte, wildcard_req, last_byte,
                  input ready);
  modport sink (input valid, mode, entry_index, item_byte, wildcard_req, last_byte,
                output ready);
endinterface

/* src/wbss_out_if.sv */
// result channel: found flag and match offset
`timescale 1ns / 1ps
interface wbss_out_if;
  import wbss_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [OFS_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

/* src/wildcard_byte_signature_scan.sv */
// top level of the wildcard byte signature scanner
//
//  port      dir   handshake          payload
//  in_ch     in    valid / ready      mode, entry_index, item_byte, wildcard_req, last_byte
//  out_ch    out   valid / ready      found, match_offset
//  cfg_*     in    cfg_we             cfg_wdata = pattern_length
//
// load and scan items are accepted while in_ready is high; a result sits in the output register
// and the next item is accepted only in a cycle where that result is taken.
// the pattern entries sit in a ring aligned to the newest window bytes; after each
// pattern_length write the ring rotates one place a cycle, with in_ready low until it
// is aligned. the reset offset already suits length 1.
// reset is synchronous, active low; window bytes and pattern entries are not reset.
`timescale 1ns / 1ps
module wildcard_byte_signature_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  wbss_in_if.sink                    in_ch,
  wbss_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [wbss_pkg::CFG_W-1:0] cfg_wdata
);
  import wbss_pkg::*;

  logic [CFG_W-1:0]  len_r;
  logic [IDX_W-1:0]  off_r, off_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt, fill_inc;
  logic [OFS_W-1:0]  seen_r, seen_nxt;
  logic              matched_r, matched_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  tgt_full;
  logic [IDX_W-1:0]  tgt;
  logic              aligned;
  logic              accept, scan_acc, load_acc;
  logic [IDX_W:0]    addr_sum;
  logic [IDX_W-1:0]  wr_addr;
  logic              idx_ok;
  logic              all_eq;
  logic              hit;
  row_ctrl_t         ctrl;
  pat_entry_t        load_pat;

  // out of range lengths clamp to 1..MAX_PATTERN
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(len_r) > LEN_W'(MAX_PATTERN) ||
                 CFG_W > LEN_W && len_r > CFG_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(len_r);
    end
  end

  // pattern entry i belongs in cell i + (MAX_PATTERN - length)
  assign tgt_full = LEN_W'(MAX_PATTERN) - len_eff;
  assign tgt      = tgt_full[IDX_W-1:0];
  assign aligned  = (off_r == tgt);

  assign in_ch.ready = aligned && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign scan_acc    = accept && (in_ch.mode == MODE_SCAN);
  assign load_acc    = accept && (in_ch.mode == MODE_LOAD);

  assign idx_ok   = (LEN_W'(in_ch.entry_index) < LEN_W'(MAX_PATTERN));
  assign addr_sum = (IDX_W + 1)'(in_ch.entry_index) + {1'b0, off_r};
  assign wr_addr  = (addr_sum >= (IDX_W + 1)'(MAX_PATTERN)) ?
                    IDX_W'(addr_sum - (IDX_W + 1)'(MAX_PATTERN)) : addr_sum[IDX_W-1:0];

  assign load_pat.any   = in_ch.wildcard_req;
  assign load_pat.value = in_ch.item_byte;

  assign ctrl.scan_en   = scan_acc && !matched_r;
  assign ctrl.rot_en    = !aligned;
  assign ctrl.load_en   = load_acc && idx_ok;
  assign ctrl.load_addr = wr_addr;
  assign ctrl.offset    = off_r;

  wbss_row u_row (
    .clk       (clk),
    .ctrl      (ctrl),
    .scan_byte (in_ch.item_byte),
    .load_pat  (load_pat),
    .all_eq    (all_eq)
  );

  assign fill_inc = (fill_r == LEN_W'(MAX_PATTERN)) ? fill_r : fill_r + LEN_W'(1);
  assign hit      = (fill_inc >= len_eff) && all_eq;
  assign off_nxt  = aligned ? off_r :
                    (off_r == IDX_W'(MAX_PATTERN - 1)) ? '0 : off_r + IDX_W'(1);

  always_comb begin
    seen_nxt      = seen_r;
    matched_nxt   = matched_r;
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    ofs_nxt       = ofs_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (scan_acc) begin
      if (matched_r) begin
        // rest of the region after a hit gives no item
        if (in_ch.last_byte) begin
          seen_nxt    = '0;
          matched_nxt = 1'b0;
          fill_nxt    = '0;
        end else begin
          seen_nxt = seen_r + OFS_W'(1);
        end
      end else if (hit) begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b1;
        ofs_nxt       = seen_r - OFS_W'(len_eff) + OFS_W'(1);
        if (in_ch.last_byte) begin
          seen_nxt    = '0;
          matched_nxt = 1'b0;
          fill_nxt    = '0;
        end else begin
          seen_nxt    = seen_r + OFS_W'(1);
          matched_nxt = 1'b1;
          fill_nxt    = fill_inc;
        end
      end else if (in_ch.last_byte) begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b0;
        ofs_nxt       = '0;
        seen_nxt      = '0;
        matched_nxt   = 1'b0;
        fill_nxt      = '0;
      end else begin
        seen_nxt = seen_r + OFS_W'(1);
        fill_nxt = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= CFG_W'(1);
      off_r       <= IDX_W'(MAX_PATTERN - 1);
      fill_r      <= '0;
      seen_r      <= '0;
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      off_r       <= off_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      matched_r   <= matched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    ofs_r   <= ofs_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.match_offset = ofs_r;

endmodule

/* src/wbss_cell.sv */
// one cell: a window byte, a pattern entry and its comparator
`timescale 1ns / 1ps
module wbss_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [wbss_pkg::BYTE_W-1:0] win_in,
  output logic [wbss_pkg::BYTE_W-1:0] win_out,
  input  logic                       rot_en,
  input  wbss_pkg::pat_entry_t       pat_in,
  output wbss_pkg::pat_entry_t       pat_out,
  input  logic                       wr_en,
  input  wbss_pkg::pat_entry_t       wr_pat,
  input  logic                       active,
  output logic                       eq
);
  import wbss_pkg::*;

  logic [BYTE_W-1:0] win_r;
  pat_entry_t        pat_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= win_in;
    end
    if (wr_en) begin
      pat_r <= wr_pat;
    end else if (rot_en) begin
      pat_r <= pat_in;
    end
  end

  // compare against the byte this cell takes on the current shift
  assign eq      = !active || pat_r.any || (win_in == pat_r.value);
  assign win_out = win_r;
  assign pat_out = pat_r;

endmodule

/* src/wbss_row.sv */
// row of cells: window shifts towards cell 0, pattern ring rotates upwards
`timescale 1ns / 1ps
module wbss_row (
  input  logic                        clk,
  input  wbss_pkg::row_ctrl_t         ctrl,
  input  logic [wbss_pkg::BYTE_W-1:0] scan_byte,
  input  wbss_pkg::pat_entry_t        load_pat,
  output logic                        all_eq
);
  import wbss_pkg::*;

  logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
  pat_entry_t             pat_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;

  for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
    localparam logic [IDX_W-1:0] CIDX = IDX_W'(c);
    localparam int UP = (c == MAX_PATTERN - 1) ? c : c + 1;
    localparam int DN = (c == 0) ? MAX_PATTERN - 1 : c - 1;

    logic [BYTE_W-1:0] win_in;

    // newest byte enters at the top cell
    assign win_in = (c == MAX_PATTERN - 1) ? scan_byte : win_q[UP];

    wbss_cell u_cell (
      .clk      (clk),
      .shift_en (ctrl.scan_en),
      .win_in   (win_in),
      .win_out  (win_q[c]),
      .rot_en   (ctrl.rot_en),
      .pat_in   (pat_q[DN]),
      .pat_out  (pat_q[c]),
      .wr_en    (ctrl.load_en && (ctrl.load_addr == CIDX)),
      .wr_pat   (load_pat),
      .active   (CIDX >= ctrl.offset),
      .eq       (eq_vec[c])
    );
  end

  assign all_eq = &eq_vec;

endmodule

/* src/wbss_checker.sv */
// port-level checks on the scanner, bound to the top level
`timescale 1ns / 1ps
module wbss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_mode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [wbss_pkg::OFS_W-1:0]  out_match_offset
);
  import wbss_pkg::*;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_match_offset))
    else $error("result changed while stalled");

  // a miss carries offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("not-found result with nonzero offset");

  // a new result only follows an accepted item
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted item");

  // load items give no result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_LOAD |=> !$rose(out_valid))
    else $error("load item produced a result");

endmodule

bind wildcard_byte_signature_scan wbss_checker u_wbss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_match_offset (out_ch.match_offset)
);
